// ----- hw/rtl/rtv_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
`default_nettype none
package rtv_pkg;

    localparam int QBITS = 17;  // quotient bits, enough for a saturation of exactly 1.0
    localparam int DW    = 11;  // divisor width, holds 6 * 255
    localparam int RW    = 12;  // partial remainder width, holds twice the divisor

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [7:0]  brightness;
    } t_hsv;

    typedef struct packed {
        logic [RW-1:0]    sat_rem;
        logic [DW-1:0]    sat_div;
        logic [QBITS-1:0] sat_q;
        logic [RW-1:0]    hue_rem;
        logic [DW-1:0]    hue_div;
        logic [QBITS-1:0] hue_q;
        logic [7:0]       bright;
    } t_stage;

endpackage
`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front cell followed by a chain of division cells.
//
// One pixel request is taken every clock while o_in_stall is low, and its HSV result
// passes through the front cell, then 17 division cells, each producing one quotient
// bit of saturation and of hue. A stalled output only stops the cells that are full,
// so empty cells further up keep taking requests.
`default_nettype none
module rgb_to_hsv_converter
    import rtv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_rgb i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_hsv      o_out_data
);

    logic   valid [QBITS+1];
    logic   ready [QBITS+2];
    t_stage stage [QBITS+1];

    assign ready[QBITS+1] = !i_out_stall;

    rtv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_pix   (i_in_data),
        .o_ready (ready[0]),
        .i_ready (ready[1]),
        .o_valid (valid[0]),
        .o_stage (stage[0])
    );

    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        rtv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .i_stage (stage[k]),
            .o_ready (ready[k+1]),
            .i_ready (ready[k+2]),
            .o_valid (valid[k+1]),
            .o_stage (stage[k+1])
        );
    end

    assign o_in_stall             = !ready[0];
    assign o_out_valid            = valid[QBITS];
    assign o_out_data.hue         = stage[QBITS].hue_q[15:0];
    assign o_out_data.saturation  = stage[QBITS].sat_q;
    assign o_out_data.brightness  = stage[QBITS].bright;

endmodule
`default_nettype wire

// ----- hw/rtl/rtv_prep.sv -----
// Front cell: finds value, chroma and the hue numerator and sets up both divisions.
`default_nettype none
module rtv_prep
    import rtv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_rgb   i_pix,
    output logic        o_ready,
    input  wire logic   i_ready,
    output logic        o_valid,
    output t_stage      o_stage
);

    logic        r_valid;
    t_stage      r_stage;
    t_stage      n_stage;
    logic [7:0]  v, mn, c;
    logic signed [RW-1:0] num;
    logic [DW-1:0] six_c;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        v = i_pix.red;
        if (i_pix.green > v) v = i_pix.green;
        if (i_pix.blue > v) v = i_pix.blue;
        mn = i_pix.red;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn) mn = i_pix.blue;
        c = v - mn;
        six_c = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
        if (v == i_pix.red) begin
            num = $signed({4'b0, i_pix.green}) - $signed({4'b0, i_pix.blue});
        end else if (v == i_pix.green) begin
            num = $signed({4'b0, i_pix.blue}) - $signed({4'b0, i_pix.red})
                + $signed({3'b0, c, 1'b0});
        end else begin
            num = $signed({4'b0, i_pix.red}) - $signed({4'b0, i_pix.green})
                + $signed({2'b0, c, 2'b0});
        end
        if (num < 0) num = num + $signed({1'b0, six_c});

        n_stage.bright  = v;
        n_stage.sat_q   = '0;
        n_stage.hue_q   = '0;
        // A grey pixel divides zero by one, which gives zero for both fields.
        if (c == 8'd0) begin
            n_stage.sat_rem = '0;
            n_stage.sat_div = DW'(1);
            n_stage.hue_rem = '0;
            n_stage.hue_div = DW'(1);
        end else begin
            n_stage.sat_rem = RW'(c);
            n_stage.sat_div = DW'(v);
            n_stage.hue_rem = num;
            n_stage.hue_div = six_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

// ----- hw/rtl/rtv_div_cell.sv -----
// Division cell: one restoring step of both the saturation and the hue quotient.
`default_nettype none
module rtv_div_cell
    import rtv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_stage i_stage,
    output logic        o_ready,
    input  wire logic   i_ready,
    output logic        o_valid,
    output t_stage      o_stage
);

    logic        r_valid;
    t_stage      r_stage;
    t_stage      n_stage;
    logic        sat_bit, hue_bit;
    logic [RW-1:0] sat_left, hue_left;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        sat_bit  = i_stage.sat_rem >= RW'(i_stage.sat_div);
        hue_bit  = i_stage.hue_rem >= RW'(i_stage.hue_div);
        sat_left = sat_bit ? i_stage.sat_rem - RW'(i_stage.sat_div) : i_stage.sat_rem;
        hue_left = hue_bit ? i_stage.hue_rem - RW'(i_stage.hue_div) : i_stage.hue_rem;
        n_stage         = i_stage;
        n_stage.sat_rem = {sat_left[RW-2:0], 1'b0};
        n_stage.hue_rem = {hue_left[RW-2:0], 1'b0};
        n_stage.sat_q   = {i_stage.sat_q[QBITS-2:0], sat_bit};
        n_stage.hue_q   = {i_stage.hue_q[QBITS-2:0], hue_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire
